### src/chained_range_map_translate_defines.svh
// Assertion macros shared by the checker of chained_range_map_translate.
// No dependencies; the user supplies clk and arst_n in scope.
`ifndef CHAINED_RANGE_MAP_TRANSLATE_DEFINES_SVH
`define CHAINED_RANGE_MAP_TRANSLATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CRMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CRMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/crmt_pkg.sv
// Package for chained_range_map_translate: sizes, command codes, FSM states, entry types.
// No dependencies.
package crmt_pkg;

	localparam int STAGES  = 7;
	localparam int ENTRIES = 64;
	localparam int DEPTH   = STAGES * ENTRIES;

	localparam int TBL_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SLOT_CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int STG_CW  = (STAGES > 1) ? $clog2(STAGES) : 1;

	typedef enum logic [1:0] {
		CMD_WRITE     = 2'd0,
		CMD_TRANSLATE = 2'd1,
		CMD_CLEAR     = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FETCH,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] src;
		logic [31:0] len;
	} entry_t;

	typedef struct packed {
		logic        hit;    // value falls in this entry's source range
		logic        stop;   // zero length: end of the stage
		logic [31:0] value;  // translated value when hit
	} match_t;

endpackage

### src/chained_range_map_translate.sv
// Top level of the chained range-map translator: table memory, scan sequencer, result regs.
// Depends on crmt_pkg and crmt_match.
//
// Usage: drive cmd and its fields with start high; the word is taken at a clock edge where
// busy is low. A write (cmd 0) loads one entry of one stage at that edge; writes to
// a stage or slot beyond the table are dropped. A clear (cmd 2) sets the running minimum to
// all ones. A translate (cmd 1) walks the stages in order, fetching one entry through the
// table memory's read port and testing it in the shared match unit, a fetch state then an
// evaluate state per entry examined. A stage ends at the first hit, at a zero-length entry,
// or after its last slot, and busy stays high until the last stage ends. The registered
// memory read plus the match unit set that fetch and evaluate step. When busy drops, done
// pulses for exactly one cycle with location and min_location; the receiver cannot stall,
// so capture them then. The next command may be accepted in that same cycle. After reset
// the block sweeps the table once to clear every length, one entry per cycle, keeping busy
// high until all DEPTH = 448 entries are cleared.
module chained_range_map_translate import crmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [2:0]  stage,
	input  logic [5:0]  slot,
	input  logic [31:0] dest_base,
	input  logic [31:0] source_base,
	input  logic [31:0] span_length,
	input  logic [31:0] seed_value,
	output logic        done,
	output logic [31:0] location,
	output logic [31:0] min_location
);

	// table memory: one word per entry holding dest, src and length
	entry_t mem [DEPTH];
	entry_t rd_q;

	state_t state_q, state_d;

	logic [TBL_AW-1:0]  clr_q;     // clearing sweep address
	logic [STG_CW-1:0]  stage_q;   // stage being scanned
	logic [SLOT_CW-1:0] slot_q;    // slot being scanned
	logic [31:0]        v_q;       // value in flight
	logic [31:0]        min_q;     // running minimum
	logic               done_q;
	logic [31:0]        location_q;
	logic [31:0]        min_out_q;

	logic               mem_we;
	logic [TBL_AW-1:0]  mem_waddr;
	entry_t             mem_wdata;
	logic [TBL_AW-1:0]  rd_addr;

	logic               accept;
	logic               wr_in_range;
	logic               stage_end;
	logic               last_stage;
	logic [31:0]        v_next;
	logic [31:0]        min_next;
	match_t             m;

	crmt_match u_match (
		.value  (v_q),
		.entry  (rd_q),
		.result (m)
	);

	assign accept      = start && !busy;
	assign wr_in_range = (32'(stage) < STAGES) && (32'(slot) < ENTRIES);
	assign rd_addr     = TBL_AW'(32'(stage_q) * ENTRIES + 32'(slot_q));

	// a stage ends on a hit, a zero length, or its last slot
	assign stage_end  = m.hit || m.stop || (slot_q == SLOT_CW'(ENTRIES - 1));
	assign last_stage = (stage_q == STG_CW'(STAGES - 1));
	assign v_next     = m.hit ? m.value : v_q;
	assign min_next   = (v_next < min_q) ? v_next : min_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (clr_q == TBL_AW'(DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && (cmd_t'(cmd) == CMD_TRANSLATE))
					state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_EVAL;
			ST_EVAL: begin
				if (stage_end && last_stage)
					state_d = ST_IDLE;
				else
					state_d = ST_FETCH;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// outputs of the sequencer: busy and the memory write port
	always_comb begin
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = TBL_AW'(32'(stage) * ENTRIES + 32'(slot));
		mem_wdata = '{dest: dest_base, src: source_base, len: span_length};
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				busy   = 1'b0;
				mem_we = start && (cmd_t'(cmd) == CMD_WRITE) && wr_in_range;
			end
			ST_FETCH, ST_EVAL: busy = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q   <= '0;
			stage_q <= '0;
			slot_q  <= '0;
			min_q   <= '1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EVAL) && stage_end && last_stage;
			if (state_q == ST_INIT)
				clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE && accept) begin
				stage_q <= '0;
				slot_q  <= '0;
				if (cmd_t'(cmd) == CMD_CLEAR)
					min_q <= '1;
			end
			if (state_q == ST_EVAL) begin
				if (stage_end) begin
					stage_q <= stage_q + 1'b1;
					slot_q  <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
				if (stage_end && last_stage)
					min_q <= min_next;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept)
			v_q <= seed_value;
		else if (state_q == ST_EVAL)
			v_q <= v_next;
		if (state_q == ST_EVAL && stage_end && last_stage) begin
			location_q <= v_next;
			min_out_q  <= min_next;
		end
	end

	assign done         = done_q;
	assign location     = location_q;
	assign min_location = min_out_q;

endmodule

### src/crmt_match.sv
// Shared range-match unit: one subtract, one compare, one add per entry.
// Depends on crmt_pkg.
module crmt_match import crmt_pkg::*; (
	input  logic [31:0] value,
	input  entry_t      entry,
	output match_t      result
);

	logic        borrow;
	logic [31:0] offset;

	// borrow set means value < src
	assign {borrow, offset} = {1'b0, value} - {1'b0, entry.src};

	always_comb begin
		result.stop  = (entry.len == 32'd0);
		result.hit   = !borrow && (offset < entry.len);
		result.value = entry.dest + offset;
	end

endmodule

### src/crmt_checker.sv
// Port-level checker for chained_range_map_translate, bound to the top level.
// Depends on crmt_pkg and chained_range_map_translate_defines.svh.
`include "chained_range_map_translate_defines.svh"

module crmt_checker import crmt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  cmd,
	input logic        done,
	input logic [31:0] location,
	input logic [31:0] min_location
);

	logic take_xlate;

	assign take_xlate = start && !busy && (cmd_t'(cmd) == CMD_TRANSLATE);

	// result comes out as the scan finishes
	`CRMT_ASSERT_NOW(a_done_idle, done, !busy, "done while busy")
	// the minimum includes the current location
	`CRMT_ASSERT_NOW(a_min_le_loc, done, min_location <= location, "min above location")
	// a translate is still busy, with no done, in the cycle after it is taken
	`CRMT_ASSERT_NEXT(a_xlate_busy, take_xlate, busy && !done, "translate not busy")
	`CRMT_ASSERT_NEXT(a_done_pulse, done, !done, "done held two cycles")

endmodule

bind chained_range_map_translate crmt_checker u_crmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.cmd          (cmd),
	.done         (done),
	.location     (location),
	.min_location (min_location)
);
